### rtl/ehc_pkg.sv
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types and fixed field constants of the escape histogram colorizer.
// ----------------------------------------------------------------------------
package ehc_pkg;

    // fixed field widths of the stream and configuration ports
    localparam int INT_W     = 10;
    localparam int FRAC_IN_W = 16;
    localparam int PC_W      = 23;
    localparam int COLOR_W   = 8;
    localparam int TDATA_W   = 32;
    localparam int RGB_W     = 3 * COLOR_W;

    localparam logic [PC_W-1:0] PC_RESET = 23'd2073600;

    // color code: band in the upper bits, ramp in the lower 8 bits
    localparam int CODE_W = 12;
    localparam int RAMP_W = 8;
    localparam int BAND_W = CODE_W - RAMP_W;
    localparam int STEP_W = 4;

    // 1791 = 2^11 - 2^8 - 1
    localparam int SPAN_SHIFT_HI = 11;
    localparam int SPAN_SHIFT_LO = 8;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

### rtl/escape_histogram_colorizer.sv
// ----------------------------------------------------------------------------
// escape_histogram_colorizer
// Histogram-equalized coloring of fractional escape counts in two passes.
// ----------------------------------------------------------------------------
// Timing: after reset the bin memory is cleared, during which no pixel is
// taken. A count pixel does one read and one write of its bin. A count pixel
// that starts a new count pass adds a clear sweep first; the count pixel marked
// tlast adds the running-total sweep (read, add, write back per bin). A color
// pixel takes two bin reads, the interpolation multiply, then the restoring
// divider that yields one code bit per cycle; pixels whose code is known to be
// black skip the divider. The result sits in an output register, so the next
// pixel is taken while it waits.
// ----------------------------------------------------------------------------
module escape_histogram_colorizer #(
    parameter int ESCAPE_LEVELS = 1024,
    parameter int COUNT_BITS    = 22,
    parameter int FRAC_BITS     = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration: pixel_count
    input  logic                        cfg_we,
    input  logic [ehc_pkg::PC_W-1:0]    cfg_wdata,
    // pixel stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [9:0] escape_int, [25:10] escape_frac, [31:26] zero
    input  logic [ehc_pkg::TDATA_W-1:0] s_axis_tdata,
    // [0] kind
    input  logic                        s_axis_tuser,
    input  logic                        s_axis_tlast,
    // color stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [ehc_pkg::RGB_W-1:0]   m_axis_tdata
);
    import ehc_pkg::*;

    localparam int DEPTH   = ESCAPE_LEVELS + 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int PROD_W  = FRAC_BITS + COUNT_BITS;
    localparam int NW      = COUNT_BITS + FRAC_BITS + 1;
    localparam int DEN_W   = PC_W + FRAC_BITS;
    localparam int NUM_W   = NW + SPAN_SHIFT_HI;
    localparam int CMP_W   = (NW > DEN_W) ? NW + 1 : DEN_W + 1;

    localparam logic [AW-1:0] LAST_ADDR = AW'(ESCAPE_LEVELS);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_CNT_RD    = 4'd2;
    localparam logic [3:0] S_CNT_WR    = 4'd3;
    localparam logic [3:0] S_SCAN_RD   = 4'd4;
    localparam logic [3:0] S_SCAN_WR   = 4'd5;
    localparam logic [3:0] S_COL_RD0   = 4'd6;
    localparam logic [3:0] S_COL_RD1   = 4'd7;
    localparam logic [3:0] S_COL_MUL   = 4'd8;
    localparam logic [3:0] S_COL_SUM   = 4'd9;
    localparam logic [3:0] S_COL_SCALE = 4'd10;
    localparam logic [3:0] S_COL_DIV   = 4'd11;
    localparam logic [3:0] S_EMIT      = 4'd12;

    logic [3:0]            state_reg, state_next;
    logic [AW-1:0]         addr_reg,  addr_next;
    logic                  phase_reg, phase_next;
    logic                  pend_reg,  pend_next;
    logic [PC_W-1:0]       pc_reg;
    logic                  out_valid_reg, out_valid_next;
    rgb_t                  out_rgb_reg,   out_rgb_next;

    logic [AW-1:0]         v_reg,    v_next;
    logic [FRAC_BITS-1:0]  f_reg,    f_next;
    logic                  last_reg, last_next;
    logic [COUNT_BITS-1:0] acc_reg,  acc_next;
    logic [COUNT_BITS-1:0] lo_reg,   lo_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [NW-1:0]         n_reg,    n_next;
    logic [DEN_W-1:0]      d_reg,    d_next;
    logic                  ovf_reg,  ovf_next;

    logic                  in_xfer;
    logic [31:0]           esc_wide;
    logic [FRAC_IN_W+FRAC_BITS-1:0] frac_ext;
    logic [AW-1:0]         v_in;
    logic [COUNT_BITS:0]   scan_sum;
    logic [COUNT_BITS-1:0] scan_sat;
    logic [COUNT_BITS-1:0] diff;
    logic [PC_W-1:0]       pc_eff;
    logic [NUM_W-1:0]      num;
    logic                  too_big;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;

    logic                  div_start;
    div_sts_t              div_sts;
    logic [CODE_W-1:0]     div_quo;
    rgb_t                  pal_rgb;

    ehc_hist_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (COUNT_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ehc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (d_reg),
        .sts   (div_sts),
        .quo   (div_quo)
    );

    ehc_palette u_pal (
        .code (div_quo),
        .ovf  (ovf_reg),
        .rgb  (pal_rgb)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // clamp the level, scale the fraction to FRAC_BITS
    assign esc_wide = 32'(s_axis_tdata[INT_W-1:0]);
    assign v_in     = (esc_wide >= ESCAPE_LEVELS) ? AW'(ESCAPE_LEVELS - 1) : AW'(esc_wide);
    assign frac_ext = {s_axis_tdata[INT_W +: FRAC_IN_W], {FRAC_BITS{1'b0}}};

    // running total, saturating
    assign scan_sum = {1'b0, acc_reg} + {1'b0, mem_rdata};
    assign scan_sat = scan_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : scan_sum[COUNT_BITS-1:0];

    assign diff    = (mem_rdata > lo_reg) ? mem_rdata - lo_reg : '0;
    assign pc_eff  = (pc_reg == '0) ? PC_W'(1) : pc_reg;

    // N * 1791 by shift and subtract
    assign num = (NUM_W'(n_reg) << SPAN_SHIFT_HI) - (NUM_W'(n_reg) << SPAN_SHIFT_LO)
               - NUM_W'(n_reg);
    // N >= 2d means a code of at least 3582: black, no division needed
    assign too_big = CMP_W'(n_reg) >= (CMP_W'(d_reg) << 1);

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        phase_next     = phase_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_rgb_next   = out_rgb_reg;
        v_next         = v_reg;
        f_next         = f_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        prod_next      = prod_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        ovf_next       = ovf_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = v_reg;
        div_start      = 1'b0;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_CNT_RD : S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    v_next    = v_in;
                    f_next    = frac_ext[FRAC_IN_W+FRAC_BITS-1 -: FRAC_BITS];
                    last_next = s_axis_tlast;
                    if (s_axis_tuser)
                    begin
                        state_next = S_COL_RD0;
                    end
                    else if (phase_reg)
                    begin
                        // new count pass: wipe the totals first, then count
                        phase_next = 1'b0;
                        pend_next  = 1'b1;
                        addr_next  = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_CNT_RD;
                    end
                end
            end
            S_CNT_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = v_reg;
                mem_wdata = (mem_rdata == {COUNT_BITS{1'b1}}) ? mem_rdata
                                                               : mem_rdata + 1'b1;
                if (last_reg)
                begin
                    addr_next  = '0;
                    acc_next   = '0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = addr_reg;
                state_next = S_SCAN_WR;
            end
            S_SCAN_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = scan_sat;
                acc_next  = scan_sat;
                if (addr_reg == LAST_ADDR)
                begin
                    phase_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_COL_RD0:
            begin
                mem_re     = 1'b1;
                state_next = S_COL_RD1;
            end
            S_COL_RD1:
            begin
                lo_next    = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = v_reg + 1'b1;
                state_next = S_COL_MUL;
            end
            S_COL_MUL:
            begin
                prod_next  = PROD_W'(f_reg) * PROD_W'(diff);
                state_next = S_COL_SUM;
            end
            S_COL_SUM:
            begin
                n_next     = (NW'(lo_reg) << FRAC_BITS) + NW'(prod_reg);
                d_next     = {pc_eff, {FRAC_BITS{1'b0}}};
                state_next = S_COL_SCALE;
            end
            S_COL_SCALE:
            begin
                ovf_next = too_big;
                if (too_big)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_COL_DIV;
                end
            end
            S_COL_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_rgb_next   = pal_rgb;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            phase_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pc_reg        <= PC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_rgb_reg <= out_rgb_next;
        v_reg       <= v_next;
        f_reg       <= f_next;
        last_reg    <= last_next;
        acc_reg     <= acc_next;
        lo_reg      <= lo_next;
        prod_reg    <= prod_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        ovf_reg     <= ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_rgb_reg;

endmodule

### rtl/ehc_hist_mem.sv
// ----------------------------------------------------------------------------
// ehc_hist_mem
// Histogram bin memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ehc_hist_mem #(
    parameter int DEPTH  = 1025,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 22
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ehc_divider.sv
// ----------------------------------------------------------------------------
// ehc_divider
// Restoring divider: one compare and subtract per cycle, CODE_W quotient bits.
// The caller guarantees the quotient fits in CODE_W bits.
// ----------------------------------------------------------------------------
module ehc_divider #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 39
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]             den,
    output ehc_pkg::div_sts_t            sts,
    output logic [ehc_pkg::CODE_W-1:0]   quo
);
    import ehc_pkg::*;

    localparam int CW = (NUM_W > DEN_W + CODE_W) ? NUM_W : DEN_W + CODE_W;

    logic [CW-1:0]     rem_reg,  rem_next;
    logic [CW-1:0]     dsh_reg,  dsh_next;
    logic [CODE_W-1:0] quo_reg,  quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = CW'(num);
            dsh_next  = CW'(den) << (CODE_W - 1);
            quo_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next  = {quo_reg[CODE_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CODE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;

endmodule

### rtl/ehc_palette.sv
// ----------------------------------------------------------------------------
// ehc_palette
// Maps a color code to a palette color: seven ramps of 256 steps, then black.
// ----------------------------------------------------------------------------
module ehc_palette (
    input  logic [ehc_pkg::CODE_W-1:0] code,
    input  logic                       ovf,
    output ehc_pkg::rgb_t              rgb
);
    import ehc_pkg::*;

    localparam logic [BAND_W-1:0] BAND_RED_UP     = 4'd0;
    localparam logic [BAND_W-1:0] BAND_GREEN_UP   = 4'd1;
    localparam logic [BAND_W-1:0] BAND_RED_DOWN   = 4'd2;
    localparam logic [BAND_W-1:0] BAND_BLUE_UP    = 4'd3;
    localparam logic [BAND_W-1:0] BAND_GREEN_DOWN = 4'd4;
    localparam logic [BAND_W-1:0] BAND_RED_BACK   = 4'd5;
    localparam logic [BAND_W-1:0] BAND_FADE       = 4'd6;

    localparam logic [COLOR_W-1:0] FULL = 8'hFF;

    logic [BAND_W-1:0]  band;
    logic [RAMP_W-1:0]  ramp;

    assign band = code[CODE_W-1:RAMP_W];
    assign ramp = code[RAMP_W-1:0];

    always_comb
    begin
        rgb = '0;
        if (!ovf)
        begin
            unique case (band)
                BAND_RED_UP:
                begin
                    rgb.red = ramp;
                end
                BAND_GREEN_UP:
                begin
                    rgb.red   = FULL;
                    rgb.green = ramp;
                end
                BAND_RED_DOWN:
                begin
                    rgb.red   = ~ramp;
                    rgb.green = FULL;
                end
                BAND_BLUE_UP:
                begin
                    rgb.green = FULL;
                    rgb.blue  = ramp;
                end
                BAND_GREEN_DOWN:
                begin
                    rgb.green = ~ramp;
                    rgb.blue  = FULL;
                end
                BAND_RED_BACK:
                begin
                    rgb.red  = ramp;
                    rgb.blue = FULL;
                end
                BAND_FADE:
                begin
                    rgb.red  = ~ramp;
                    rgb.blue = ~ramp;
                end
                default:
                begin
                    rgb = '0;
                end
            endcase
        end
    end

endmodule
